### rtl/complete_binary_tree_store_core_assert.svh
// assertion macros used by the asserting file of the core
`ifndef COMPLETE_BINARY_TREE_STORE_CORE_ASSERT_SVH
`define COMPLETE_BINARY_TREE_STORE_CORE_ASSERT_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/cbts_pkg.sv
`timescale 1ns / 1ps

package cbts_pkg;

  localparam int FUNC_W  = 3;
  localparam int VAL_W   = 8;
  localparam int CNT_W   = 6;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 3;
  localparam int PH_W    = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PREORDER  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INORDER   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POSTORDER = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_ELEM     = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

  // walk phase at a node; equals the order code that emits in that phase
  localparam logic [PH_W-1:0] PH_DOWN  = 2'd0;
  localparam logic [PH_W-1:0] PH_LEFT  = 2'd1;
  localparam logic [PH_W-1:0] PH_RIGHT = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic rd_walk;
    logic srch_step;
    logic emit_set;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic srch_hit;
    logic srch_end;
    logic emit_here;
    logic res_more;
  } stat_t;

  // floor(log2(p)) for p >= 1
  function automatic logic [DEPTH_W-1:0] depth_of(input logic [CNT_W-1:0] p);
    logic [DEPTH_W-1:0] d;
    d = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (p[i]) d = DEPTH_W'(i);
    end
    return d;
  endfunction

endpackage

### rtl/cbts_ctrl.sv
`timescale 1ns / 1ps

module cbts_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [cbts_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  cbts_pkg::stat_t             stat,
  output cbts_pkg::cmd_t              cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_func) inside
            cbts_pkg::FN_INSERT: state_next = S_OUT;
            cbts_pkg::FN_SEARCH: state_next = stat.empty ? S_OUT : S_SRCH_RD;
            cbts_pkg::FN_PREORDER, cbts_pkg::FN_INORDER, cbts_pkg::FN_POSTORDER:
              state_next = stat.empty ? S_OUT : S_WALK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = (stat.srch_hit || stat.srch_end) ? S_OUT : S_SRCH_RD;
      S_WALK:     state_next = stat.emit_here ? S_EMIT_RD : S_WALK;
      S_EMIT_RD:  state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = stat.res_more ? S_WALK : S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.accept    = accept;
    cmd.rd_en     = (state == S_SRCH_RD) || (state == S_EMIT_RD);
    cmd.rd_walk   = (state == S_EMIT_RD);
    cmd.srch_step = (state == S_SRCH_CMP);
    cmd.emit_set  = (state == S_EMIT_RD);
    cmd.adv       = ((state == S_WALK) && !stat.emit_here) ||
                    ((state == S_OUT) && out_ready && stat.res_more);
  end

endmodule

### rtl/cbts_datapath.sv
`timescale 1ns / 1ps

module cbts_datapath #(
  parameter int CAPACITY = 63
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cbts_pkg::cmd_t               cmd,
  input  logic [cbts_pkg::FUNC_W-1:0]  in_func,
  input  logic [cbts_pkg::VAL_W-1:0]   in_value,
  output cbts_pkg::stat_t              stat,
  output logic [cbts_pkg::STAT_W-1:0]  res_status,
  output logic [cbts_pkg::VAL_W-1:0]   res_value,
  output logic [cbts_pkg::DEPTH_W-1:0] res_depth,
  output logic                         res_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = cbts_pkg::CNT_W;

  logic [cbts_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [cbts_pkg::VAL_W-1:0] rd_data;
  logic [AW-1:0]              rd_addr;

  logic [CW-1:0]                count;
  logic [cbts_pkg::VAL_W-1:0]   key;
  logic [cbts_pkg::PH_W-1:0]    order;
  logic [CW-1:0]                pos;
  logic [cbts_pkg::PH_W-1:0]    phase;
  logic [CW-1:0]                emit_cnt;
  logic [CW-1:0]                idx;

  logic [CW-1:0]             pos_next;
  logic [cbts_pkg::PH_W-1:0] phase_next;
  logic [CW:0]               left_pos;
  logic [CW:0]               right_pos;
  logic [CW:0]               cnt_ext;
  logic [CW-1:0]             pos_m1;
  logic [CW-1:0]             idx_p1;
  logic                      full;
  logic                      do_insert;
  logic                      emit_last;

  assign full      = (count >= CW'(CAPACITY));
  assign do_insert = cmd.accept && (in_func == cbts_pkg::FN_INSERT) && !full;
  assign cnt_ext   = {1'b0, count};
  assign left_pos  = {pos, 1'b0};
  assign right_pos = {pos, 1'b1};
  assign pos_m1    = pos - CW'(1);
  assign idx_p1    = idx + CW'(1);
  assign emit_last = (emit_cnt == count - CW'(1));
  assign rd_addr   = cmd.rd_walk ? pos_m1[AW-1:0] : idx[AW-1:0];

  always_comb begin
    stat.empty     = (count == '0);
    stat.srch_hit  = (rd_data == key);
    stat.srch_end  = ({1'b0, idx_p1} >= cnt_ext);
    stat.emit_here = (phase == order);
    stat.res_more  = (res_status == cbts_pkg::ST_ELEM) && !res_last;
  end

  // one move of the stackless walk
  always_comb begin
    pos_next   = pos;
    phase_next = phase;
    case (phase)
      cbts_pkg::PH_DOWN: begin
        if (left_pos <= cnt_ext) begin
          pos_next = left_pos[CW-1:0];
        end else begin
          phase_next = cbts_pkg::PH_LEFT;
        end
      end
      cbts_pkg::PH_LEFT: begin
        if (right_pos <= cnt_ext) begin
          pos_next   = right_pos[CW-1:0];
          phase_next = cbts_pkg::PH_DOWN;
        end else begin
          phase_next = cbts_pkg::PH_RIGHT;
        end
      end
      default: begin
        if (pos != CW'(1)) begin
          pos_next   = pos >> 1;
          phase_next = pos[0] ? cbts_pkg::PH_RIGHT : cbts_pkg::PH_LEFT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) mem[count[AW-1:0]] <= in_value;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key      <= in_value;
      order    <= cbts_pkg::PH_W'(in_func - cbts_pkg::FN_PREORDER);
      pos      <= CW'(1);
      phase    <= cbts_pkg::PH_DOWN;
      emit_cnt <= '0;
      idx      <= '0;
      res_depth <= '0;
      res_last  <= 1'b1;
      case (in_func) inside
        cbts_pkg::FN_INSERT: res_status <= full ? cbts_pkg::ST_FULL : cbts_pkg::ST_INSERTED;
        cbts_pkg::FN_SEARCH: res_status <= cbts_pkg::ST_NOTFOUND;
        default:             res_status <= cbts_pkg::ST_EMPTY;
      endcase
    end
    if (cmd.srch_step) begin
      if (stat.srch_hit) begin
        res_status <= cbts_pkg::ST_FOUND;
        res_depth  <= cbts_pkg::depth_of(idx_p1);
      end else if (stat.srch_end) begin
        res_status <= cbts_pkg::ST_NOTFOUND;
      end else begin
        idx <= idx_p1;
      end
    end
    if (cmd.emit_set) begin
      res_status <= cbts_pkg::ST_ELEM;
      res_depth  <= '0;
      res_last   <= emit_last;
      emit_cnt   <= emit_cnt + CW'(1);
    end
    if (cmd.adv) begin
      pos   <= pos_next;
      phase <= phase_next;
    end
  end

  // read register holds during the output wait, no read is issued then
  assign res_value = (res_status == cbts_pkg::ST_ELEM) ? rd_data : '0;

endmodule

### rtl/complete_binary_tree_store_core.sv
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata: func[2:0], value[10:3], zero fill
// m       | out | m_tvalid/m_tready  | m_tdata: status[2:0], item_value[10:3],
//         |     |                    |   found_depth[13:11], zero fill; m_tlast
//
// one item at a time; s_tready is high only while nothing is in flight
// insert: result in the cycle after acceptance; search: a read and a compare state per entry compared
// traversal: the down, left and right walk phase at each node, plus an element read and an output state per element
// rst is synchronous: node count and controller cleared, no clearing pass over the store
// a stall on m holds the result and the walk; no new item is taken until the last result goes

module complete_binary_tree_store_core #(
  parameter int CAPACITY = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // func[2:0], value[10:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[2:0], item_value[10:3], found_depth[13:11]
  output logic        m_tlast
);

`include "complete_binary_tree_store_core_assert.svh"

  logic [cbts_pkg::FUNC_W-1:0]  in_func;
  logic [cbts_pkg::VAL_W-1:0]   in_value;
  logic [cbts_pkg::STAT_W-1:0]  res_status;
  logic [cbts_pkg::VAL_W-1:0]   res_value;
  logic [cbts_pkg::DEPTH_W-1:0] res_depth;
  logic                         res_last;
  cbts_pkg::cmd_t               cmd;
  cbts_pkg::stat_t              stat;

  // unpack the request item
  assign in_func  = s_tdata[2:0];
  assign in_value = s_tdata[10:3];

  // sequencer: idle, search read/compare, walk, element read, result out
  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_func   (in_func),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, node count, walk position and result registers
  cbts_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_func    (in_func),
    .in_value   (in_value),
    .stat       (stat),
    .res_status (res_status),
    .res_value  (res_value),
    .res_depth  (res_depth),
    .res_last   (res_last)
  );

  // pack the result item
  assign m_tdata = {2'b00, res_depth, res_value, res_status};
  assign m_tlast = res_last;

  // never take a new item while a result is pending
  `ASSERT_IMPL(a_busy_excl, clk, rst, m_tvalid, !s_tready)
  // after the final result the block is free again
  `ASSERT_NEXT(a_last_frees, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)
  // depth is only reported with a match
  `ASSERT_IMPL(a_depth_found, clk, rst,
               m_tvalid && (res_status != cbts_pkg::ST_FOUND), res_depth == '0)
  // only traversal elements can be followed by more results
  `ASSERT_IMPL(a_more_elem, clk, rst,
               m_tvalid && !m_tlast, res_status == cbts_pkg::ST_ELEM)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cbts_pkg::*;

  localparam int TREE_CAP     = 63;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block

  // request codes the block ignores
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  // one result as it leaves the block
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   item_value;
    logic [DEPTH_W-1:0] found_depth;
    logic               last;
  } tree_outcome_t;

  // shadow copy of the tree plus the results it still owes
  class tree_mirror;
    logic [VAL_W-1:0] shadow_nodes [TREE_CAP];
    int               shadow_count;
    tree_outcome_t    owed_outcomes [$];
    int               error_count;

    function new();
      shadow_count = 0;
      error_count  = 0;
    endfunction

    function void owe(logic [STAT_W-1:0] st, logic [VAL_W-1:0] v, logic [DEPTH_W-1:0] d);
      tree_outcome_t o;
      o.status      = st;
      o.item_value  = v;
      o.found_depth = d;
      o.last        = 1'b0;
      owed_outcomes.push_back(o);
    endfunction

    // floor(log2(pos)) for a 1-based heap position
    function logic [DEPTH_W-1:0] level_of(int pos);
      logic [DEPTH_W-1:0] d;
      d = '0;
      while (pos > 1) begin
        pos = pos >> 1;
        d++;
      end
      return d;
    endfunction

    // children of position p sit at 2p and 2p+1
    function void walk(int pos, logic [PH_W-1:0] order);
      if (pos > shadow_count) return;
      if (order == PH_DOWN) owe(ST_ELEM, shadow_nodes[pos-1], '0);
      walk(2 * pos, order);
      if (order == PH_LEFT) owe(ST_ELEM, shadow_nodes[pos-1], '0);
      walk(2 * pos + 1, order);
      if (order == PH_RIGHT) owe(ST_ELEM, shadow_nodes[pos-1], '0);
    endfunction

    // called once per accepted item; queues every result it causes
    function void note_request(logic [FUNC_W-1:0] fn, logic [VAL_W-1:0] v);
      int hit;
      hit = -1;
      case (fn)
        FN_INSERT: begin
          if (shadow_count >= TREE_CAP) begin
            owe(ST_FULL, '0, '0);
          end else begin
            shadow_nodes[shadow_count] = v;
            shadow_count++;
            owe(ST_INSERTED, '0, '0);
          end
        end
        FN_SEARCH: begin
          // level order scan, first match wins
          for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_nodes[i] == v) hit = i;
          end
          if (hit >= 0) owe(ST_FOUND, '0, level_of(hit + 1));
          else owe(ST_NOTFOUND, '0, '0);
        end
        FN_PREORDER, FN_INORDER, FN_POSTORDER: begin
          if (shadow_count == 0) owe(ST_EMPTY, '0, '0);
          else walk(1, PH_W'(fn - FN_PREORDER));
        end
        default: return;  // spare codes cause nothing
      endcase
      owed_outcomes[owed_outcomes.size()-1].last = 1'b1;
    endfunction

    function logic [VAL_W-1:0] any_stored();
      return shadow_nodes[$urandom_range(0, shadow_count - 1)];
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(logic [15:0] data, logic last);
      tree_outcome_t want;
      if (owed_outcomes.size() == 0) begin
        $error("result with nothing owed: status %0d item_value %0d", data[2:0], data[10:3]);
        error_count++;
        return;
      end
      want = owed_outcomes.pop_front();
      compare_field("status", 8'(want.status), 8'(data[2:0]));
      compare_field("item_value", want.item_value, data[10:3]);
      compare_field("found_depth", 8'(want.found_depth), 8'(data[13:11]));
      compare_field("last", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // func[2:0], value[10:3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // status[2:0], item_value[10:3], found_depth[13:11]
  logic        m_tlast;

  tree_mirror mirror;
  int         send_idle_pct  = 26;
  int         recv_idle_pct  = 64;
  bit         pressure_armed = 1'b0;
  int         quiet_cycles   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complete_binary_tree_store_core #(
    .CAPACITY(TREE_CAP)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // offer one item from a falling edge, return at the falling edge after acceptance;
  // tvalid stays high so back-to-back items need no gap
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'b0, val, fn};
    do @(posedge clk); while (!s_tready);
    mirror.note_request(fn, val);
    @(negedge clk);
  endtask

  task automatic offer_random_request();
    int               roll;
    logic [VAL_W-1:0] v;
    roll = $urandom_range(0, 99);
    // narrow values half the time so duplicates and search hits are common
    if ($urandom_range(0, 1) == 1) v = VAL_W'($urandom_range(0, 15));
    else v = VAL_W'($urandom_range(0, 255));
    if (roll < 30) begin
      send_request(FN_INSERT, v);
    end else if (roll < 60) begin
      if (mirror.shadow_count > 0 && $urandom_range(0, 1) == 1) v = mirror.any_stored();
      send_request(FN_SEARCH, v);
    end else if (roll < 92) begin
      send_request(FN_PREORDER + FUNC_W'($urandom_range(0, 2)), v);
    end else begin
      send_request(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), v);
    end
  endtask

  // receiver: random stalls, plus one long hold-off once pressure is armed
  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (pressure_armed && !pressure_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_result(m_tdata, m_tlast);
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("complete_binary_tree_store_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    mirror = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // empty tree: search misses, every traversal gives one empty result
    send_request(FN_SEARCH, 8'h5A);
    send_request(FN_PREORDER, 8'h00);
    send_request(FN_INORDER, 8'hFF);
    send_request(FN_POSTORDER, 8'h00);
    // spare codes are dropped without a result
    send_request(FN_SPARE_LO, 8'h00);
    send_request(FN_SPARE_LO + 3'd1, 8'hFF);
    send_request(FN_SPARE_HI, 8'hFF);
    // a small tree with a duplicate and both value extremes
    send_request(FN_INSERT, 8'h00);
    send_request(FN_INSERT, 8'hFF);
    send_request(FN_INSERT, 8'hFF);
    send_request(FN_INSERT, 8'hA5);
    send_request(FN_SEARCH, 8'h00);   // root, depth 0
    send_request(FN_SEARCH, 8'hFF);   // first copy wins, depth 1
    send_request(FN_SEARCH, 8'hA5);   // depth 2
    send_request(FN_SEARCH, 8'h12);   // miss on a non-empty tree
    send_request(FN_PREORDER, 8'h00);
    send_request(FN_INORDER, 8'h00);
    send_request(FN_POSTORDER, 8'h00);

    // random part in three idling phases; the tree fills and then drops inserts
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct  = 0;
          recv_idle_pct  = 0;
          pressure_armed = 1'b1;
        end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 3 + 1; k++) offer_random_request();
    end
    s_tvalid = 1'b0;

    // drain; the watchdog catches results that never come
    while (mirror.owed_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.error_count == 0) begin
      $display("complete_binary_tree_store_core verification clean");
    end else begin
      $display("complete_binary_tree_store_core verification failed");
    end
    $finish;
  end

endmodule
